// File: sv/assert_macros.svh
// Assertion macros shared by the border edge line scanner RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/bels_pkg.sv
// Types and constants of the border edge line scanner.
package bels_pkg;

  localparam int WIN_DEPTH = 4;
  localparam int SAMPLE_W  = 8;
  localparam int CNT_W     = $clog2(WIN_DEPTH + 1);
  localparam int SUM_W     = SAMPLE_W + $clog2(WIN_DEPTH);
  localparam int POS_W     = 11;
  localparam int LINE_SPAN = 2048;
  localparam int RATIO_W   = 24;
  localparam int FRAC_W    = 16;
  localparam int PROD_W    = SUM_W + CNT_W;
  localparam int DEN_W     = SUM_W + CNT_W;
  localparam int NUM_HI_W  = PROD_W + FRAC_W - RATIO_W;
  localparam int CMP_W     = RATIO_W + 4;

  localparam logic [SUM_W-1:0]   EPS_UNITS  = SUM_W'(1 << (SAMPLE_W - 8));
  localparam logic [POS_W-1:0]   POS_MAX    = POS_W'(LINE_SPAN - 1);
  localparam logic [RATIO_W-1:0] RATIO_MAX  = '1;
  localparam logic [RATIO_W-1:0] RATIO_ONE  = RATIO_W'(65536);
  localparam logic [CMP_W-1:0]   STOP_LIMIT = CMP_W'(720896);
  localparam logic [CMP_W-1:0]   RATIO_EPS  = CMP_W'(256);
  localparam logic [CMP_W-1:0]   MUL_TEN    = CMP_W'(10);
  localparam logic [CMP_W-1:0]   MUL_SEVEN  = CMP_W'(7);
  localparam logic [SAMPLE_W-1:0] BG_RESET  = SAMPLE_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_PREP,
    ST_DIV,
    ST_CMP,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic                start;
    logic [NUM_HI_W-1:0] num_hi;
    logic [RATIO_W-1:0]  num_lo;
    logic [DEN_W-1:0]    den;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [RATIO_W-1:0] quot;
  } div_rsp_t;

endpackage

// File: sv/bels_div.sv
// Radix-4 restoring divider for the Q8.16 mean ratio.
module bels_div (
  input  logic                clk,
  input  logic                rst_n,
  input  bels_pkg::div_req_t  req_i,
  output bels_pkg::div_rsp_t  rsp_o
);

  `include "assert_macros.svh"

  localparam int STEPS = 2;
  localparam int ITER  = bels_pkg::RATIO_W / STEPS;
  localparam int IT_W  = $clog2(ITER);

  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic [IT_W-1:0]              cnt_r, cnt_nxt;
  logic [bels_pkg::DEN_W-1:0]   rem_r, rem_nxt;
  logic [bels_pkg::DEN_W-1:0]   den_r, den_nxt;
  logic [bels_pkg::RATIO_W-1:0] sh_r, sh_nxt;
  logic [bels_pkg::DEN_W-1:0]   rem_t;
  logic [bels_pkg::RATIO_W-1:0] sh_t;

  always_comb begin
    logic [bels_pkg::DEN_W:0] trial;
    rem_t = rem_r;
    sh_t  = sh_r;
    for (int i = 0; i < STEPS; i++) begin
      trial = {rem_t, sh_t[bels_pkg::RATIO_W-1]};
      if (trial >= {1'b0, den_r}) begin
        rem_t = bels_pkg::DEN_W'(trial - {1'b0, den_r});
        sh_t  = {sh_t[bels_pkg::RATIO_W-2:0], 1'b1};
      end else begin
        rem_t = trial[bels_pkg::DEN_W-1:0];
        sh_t  = {sh_t[bels_pkg::RATIO_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    sh_nxt   = sh_r;
    if (req_i.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = IT_W'(ITER - 1);
      rem_nxt  = bels_pkg::DEN_W'(req_i.num_hi);
      den_nxt  = req_i.den;
      sh_nxt   = req_i.num_lo;
    end else if (busy_r) begin
      rem_nxt = rem_t;
      sh_nxt  = sh_t;
      cnt_nxt = cnt_r - IT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    sh_r  <= sh_nxt;
  end

  assign rsp_o.busy = busy_r;
  assign rsp_o.done = done_r;
  assign rsp_o.quot = sh_r;

  `ASSERT_ALWAYS(a_start_when_free, req_i.start |-> !busy_r, "divide started while busy")
  `ASSERT_NEXT(a_start_runs, req_i.start, busy_r && !done_r, "divide did not start")
  `ASSERT_NEXT(a_done_pulse, done_r, !done_r, "divide done held for more than one cycle")

endmodule

// File: sv/border_edge_line_scanner.sv
// Border edge line scanner: top level with window state, sequencer and result register.
// One sample is accepted when in_stall is low, then the block stalls its input until that
// sample is finished. A sample whose ratio goes through the divider passes the accept state,
// window update, divide setup, 12 steps of the radix-4 divider, a step to hand back the
// quotient, best/stop compare and a finish step. A ratio that saturates skips the divider. A
// sample ignored after a stop leaves the window as it is and goes to the finish step; one
// whose older window is still too dark skips the divider and compare. The last sample of a
// line writes the result register; if a previous result is still stalled there, the finish
// step waits for it. The cfg_wr_data background level is used at the first sample of each line.
module border_edge_line_scanner (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_intensity,
  input  logic        in_last_of_line,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [10:0] out_edge_offset,
  output logic [23:0] out_edge_strength,
  output logic        out_stopped_early
);

  `include "assert_macros.svh"

  localparam int WD = bels_pkg::WIN_DEPTH;
  localparam int SW = bels_pkg::SAMPLE_W;
  localparam int CW = bels_pkg::CNT_W;
  localparam int MW = bels_pkg::SUM_W;
  localparam int PW = bels_pkg::POS_W;
  localparam int RW = bels_pkg::RATIO_W;
  localparam int CMW = bels_pkg::CMP_W;
  localparam int NW = bels_pkg::PROD_W + bels_pkg::FRAC_W;

  bels_pkg::state_t state_r, state_nxt;

  logic [SW-1:0] bg_r;
  logic [SW-1:0] samp_r;
  logic          last_r;
  logic [SW-1:0] nw_r [WD];
  logic [SW-1:0] nw_nxt [WD];
  logic [SW-1:0] ow_r [WD];
  logic [SW-1:0] ow_nxt [WD];
  logic [CW-1:0] ncount_r, ncount_nxt;
  logic [CW-1:0] ocount_r, ocount_nxt;
  logic [MW-1:0] nsum_r, nsum_nxt;
  logic [MW-1:0] osum_r, osum_nxt;
  logic [RW-1:0] best_r, best_nxt;
  logic [PW-1:0] best_pos_r, best_pos_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic          halted_r, halted_nxt;
  logic [RW-1:0] ratio_r, ratio_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [PW-1:0] out_off_r, out_off_nxt;
  logic [RW-1:0] out_str_r, out_str_nxt;
  logic          out_stop_r, out_stop_nxt;

  logic          accept;
  logic          seed;
  logic          eff_halted;
  logic          skip;
  logic          sat;
  logic          out_free;
  logic          load_out;
  logic [bels_pkg::PROD_W-1:0] prod;
  logic [NW-1:0]               num;
  logic [bels_pkg::DEN_W-1:0]  den;
  logic                        stop_hit;

  bels_pkg::div_req_t div_req;
  bels_pkg::div_rsp_t div_rsp;

  bels_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  assign accept     = in_valid && (state_r == bels_pkg::ST_IDLE);
  assign seed       = (pos_r == '0);
  assign eff_halted = !seed && halted_r;
  assign skip       = (ocount_r == '0) || (osum_r < MW'(ocount_r) * bels_pkg::EPS_UNITS);
  assign prod       = bels_pkg::PROD_W'(nsum_r) * bels_pkg::PROD_W'(ocount_r);
  assign num        = {prod, {bels_pkg::FRAC_W{1'b0}}};
  assign den        = bels_pkg::DEN_W'(osum_r) * bels_pkg::DEN_W'(ncount_r);
  assign sat        = bels_pkg::DEN_W'(num[NW-1:RW]) >= den;
  assign out_free   = !out_valid_r || !out_stall;
  assign load_out   = (state_r == bels_pkg::ST_FIN) && last_r && out_free;

  assign stop_hit = (best_r > bels_pkg::RATIO_ONE) &&
                    (CMW'(ratio_r) * bels_pkg::MUL_TEN < bels_pkg::STOP_LIMIT) &&
                    ((CMW'(ratio_r) + bels_pkg::RATIO_EPS) * bels_pkg::MUL_TEN <
                     (CMW'(best_r) + bels_pkg::RATIO_EPS) * bels_pkg::MUL_SEVEN);

  assign div_req.start  = (state_r == bels_pkg::ST_PREP) && !skip && !sat;
  assign div_req.num_hi = num[NW-1:RW];
  assign div_req.num_lo = num[RW-1:0];
  assign div_req.den    = den;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bels_pkg::ST_IDLE: if (in_valid) state_nxt = bels_pkg::ST_PUSH;
      bels_pkg::ST_PUSH: state_nxt = eff_halted ? bels_pkg::ST_FIN : bels_pkg::ST_PREP;
      bels_pkg::ST_PREP: begin
        if (skip) state_nxt = bels_pkg::ST_FIN;
        else if (sat) state_nxt = bels_pkg::ST_CMP;
        else state_nxt = bels_pkg::ST_DIV;
      end
      bels_pkg::ST_DIV:  if (div_rsp.done) state_nxt = bels_pkg::ST_CMP;
      bels_pkg::ST_CMP:  state_nxt = bels_pkg::ST_FIN;
      bels_pkg::ST_FIN:  if (!last_r || out_free) state_nxt = bels_pkg::ST_IDLE;
      default:           state_nxt = bels_pkg::ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    logic [CW-1:0] e_ncount;
    logic [CW-1:0] e_ocount;
    logic [MW-1:0] e_nsum;
    logic [MW-1:0] e_osum;
    logic          evict;
    logic          ofull;
    logic [SW-1:0] ev;
    logic [MW:0]   sum_t;
    nw_nxt       = nw_r;
    ow_nxt       = ow_r;
    ncount_nxt   = ncount_r;
    ocount_nxt   = ocount_r;
    nsum_nxt     = nsum_r;
    osum_nxt     = osum_r;
    best_nxt     = best_r;
    best_pos_nxt = best_pos_r;
    pos_nxt      = pos_r;
    halted_nxt   = halted_r;
    ratio_nxt    = ratio_r;
    out_off_nxt  = out_off_r;
    out_str_nxt  = out_str_r;
    out_stop_nxt = out_stop_r;
    out_valid_nxt = load_out || (out_valid_r && out_stall);

    e_ncount = seed ? CW'(1) : ncount_r;
    e_ocount = seed ? '0 : ocount_r;
    e_nsum   = seed ? MW'(bg_r) : nsum_r;
    e_osum   = seed ? '0 : osum_r;
    evict    = (e_ncount == CW'(WD));
    ofull    = (e_ocount == CW'(WD));
    ev       = nw_r[WD-1];
    sum_t    = '0;

    case (state_r)
      bels_pkg::ST_PUSH: begin
        if (seed) begin
          best_nxt     = '0;
          best_pos_nxt = '0;
          halted_nxt   = 1'b0;
          ncount_nxt   = e_ncount;
          ocount_nxt   = e_ocount;
          nsum_nxt     = e_nsum;
          osum_nxt     = e_osum;
        end
        if (!eff_halted) begin
          nw_nxt[0] = samp_r;
          for (int k = 1; k < WD; k++) nw_nxt[k] = nw_r[k-1];
          if (seed) nw_nxt[1] = bg_r;
          sum_t = {1'b0, e_nsum} + (MW+1)'(samp_r) - (evict ? (MW+1)'(ev) : '0);
          nsum_nxt = sum_t[MW-1:0];
          if (evict) begin
            ow_nxt[0] = ev;
            for (int k = 1; k < WD; k++) ow_nxt[k] = ow_r[k-1];
            sum_t    = {1'b0, e_osum} + (MW+1)'(ev) - (ofull ? (MW+1)'(ow_r[WD-1]) : '0);
            osum_nxt = sum_t[MW-1:0];
            if (!ofull) ocount_nxt = e_ocount + CW'(1);
          end else begin
            ncount_nxt = e_ncount + CW'(1);
          end
        end
      end
      bels_pkg::ST_PREP: if (!skip && sat) ratio_nxt = bels_pkg::RATIO_MAX;
      bels_pkg::ST_DIV:  if (div_rsp.done) ratio_nxt = div_rsp.quot;
      bels_pkg::ST_CMP: begin
        if (best_r < ratio_r) begin
          best_nxt     = ratio_r;
          best_pos_nxt = pos_r + PW'(1) - PW'(ncount_r);
        end else if (stop_hit) begin
          halted_nxt = 1'b1;
        end
      end
      bels_pkg::ST_FIN: begin
        if (!last_r) begin
          if (pos_r != bels_pkg::POS_MAX) pos_nxt = pos_r + PW'(1);
        end else if (out_free) begin
          pos_nxt      = '0;
          out_off_nxt  = best_pos_r;
          out_str_nxt  = best_r;
          out_stop_nxt = halted_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bels_pkg::ST_IDLE;
      bg_r        <= bels_pkg::BG_RESET;
      ncount_r    <= CW'(1);
      ocount_r    <= '0;
      nsum_r      <= MW'(bels_pkg::BG_RESET);
      osum_r      <= '0;
      best_r      <= '0;
      best_pos_r  <= '0;
      pos_r       <= '0;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_wr_en) bg_r <= cfg_wr_data;
      ncount_r    <= ncount_nxt;
      ocount_r    <= ocount_nxt;
      nsum_r      <= nsum_nxt;
      osum_r      <= osum_nxt;
      best_r      <= best_nxt;
      best_pos_r  <= best_pos_nxt;
      pos_r       <= pos_nxt;
      halted_r    <= halted_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      samp_r <= in_intensity;
      last_r <= in_last_of_line;
    end
    nw_r       <= nw_nxt;
    ow_r       <= ow_nxt;
    ratio_r    <= ratio_nxt;
    out_off_r  <= out_off_nxt;
    out_str_r  <= out_str_nxt;
    out_stop_r <= out_stop_nxt;
  end

  assign in_stall          = (state_r != bels_pkg::ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_edge_offset   = out_off_r;
  assign out_edge_strength = out_str_r;
  assign out_stopped_early = out_stop_r;

  `ASSERT_ALWAYS(a_result_from_fin, $rose(out_valid_r) |-> $past(state_r == bels_pkg::ST_FIN && last_r), "result without line end")
  `ASSERT_ALWAYS(a_halt_needs_best, halted_r |-> (best_r > bels_pkg::RATIO_ONE), "halt with weak best")
  `ASSERT_ALWAYS(a_div_active, (state_r == bels_pkg::ST_DIV) |-> (div_rsp.busy || div_rsp.done), "divide state with idle divider")

endmodule

// File: tb/border_edge_line_scanner_tb.sv
// Self-checking testbench for the border edge line scanner: directed lines, then random lines.
module border_edge_line_scanner_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int CHOKE_CYCLES   = 1500;
  localparam int SETTLE_CYCLES  = 24;
  localparam int RANDOM_ITEMS   = 1350;
  localparam int PHASE_ITEMS    = 160;

  typedef struct packed {
    logic [10:0] offset;
    logic [23:0] strength;
    logic        stopped;
  } edge_report_t;

  typedef enum logic {ROW_SAMPLE, ROW_BACKGROUND} row_kind_t;
  typedef enum logic [1:0] {SHAPE_STEP, SHAPE_NOISE, SHAPE_PEAK, SHAPE_FLAT} line_shape_t;

  typedef struct {
    row_kind_t    kind;
    logic [7:0]   value;
    int           count;
    bit           typed;
    edge_report_t want;
  } row_t;

  localparam edge_report_t NO_EDGE = '0;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_intensity = '0;
  logic        in_last_of_line = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [10:0] out_edge_offset;
  logic [23:0] out_edge_strength;
  logic        out_stopped_early;

  border_edge_line_scanner dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_intensity      (in_intensity),
    .in_last_of_line   (in_last_of_line),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_edge_offset   (out_edge_offset),
    .out_edge_strength (out_edge_strength),
    .out_stopped_early (out_stopped_early)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // line scan tracker state
  logic [7:0]  bg_level = 8'd1;
  logic [7:0]  recent_win [bels_pkg::WIN_DEPTH];
  logic [7:0]  aged_win [bels_pkg::WIN_DEPTH];
  int          recent_head, recent_cnt, recent_sum;
  int          aged_head, aged_cnt, aged_sum;
  logic [23:0] top_ratio;
  logic [10:0] top_pos;
  logic [10:0] scan_pos = '0;
  bit          scan_halted;

  edge_report_t pending_reports[$];
  int           mismatches = 0;
  int           quiet_cycles = 0;
  bit           lively = 1'b1;
  bit           choke_req = 1'b0;
  bit           choke_done = 1'b0;

  row_t directed_rows [8] = '{
    '{ROW_SAMPLE,     8'd0,   1, 1'b1, NO_EDGE},
    '{ROW_SAMPLE,     8'd255, 1, 1'b1, NO_EDGE},
    '{ROW_SAMPLE,     8'd10,  8, 1'b0, NO_EDGE},  // stops on its last sample
    '{ROW_BACKGROUND, 8'd0,   0, 1'b0, NO_EDGE},
    '{ROW_SAMPLE,     8'd0,   5, 1'b1, NO_EDGE},  // older window too dark
    '{ROW_SAMPLE,     8'd10,  9, 1'b0, NO_EDGE},  // stops, then ignores the rest
    '{ROW_BACKGROUND, 8'd255, 0, 1'b0, NO_EDGE},
    '{ROW_SAMPLE,     8'd255, 4, 1'b0, NO_EDGE}
  };

  function automatic void track_edge(input logic [7:0] v, input logic line_end,
                                     output bit has_report, output edge_report_t report);
    int evicted;
    longint unsigned num, den, r, b;
    has_report = 1'b0;
    report = NO_EDGE;
    if (scan_pos == 0) begin
      foreach (recent_win[i]) begin
        recent_win[i] = '0;
        aged_win[i] = '0;
      end
      recent_win[0] = bg_level;
      recent_head = 0;
      recent_cnt = 1;
      recent_sum = bg_level;
      aged_head = 0;
      aged_cnt = 0;
      aged_sum = 0;
      top_ratio = '0;
      top_pos = '0;
      scan_halted = 1'b0;
    end
    if (!scan_halted) begin
      if (recent_cnt >= bels_pkg::WIN_DEPTH) begin
        evicted = recent_win[recent_head];
        recent_sum -= evicted;
        recent_win[recent_head] = v;
        recent_head = (recent_head + 1) % bels_pkg::WIN_DEPTH;
        if (aged_cnt >= bels_pkg::WIN_DEPTH) begin
          aged_sum -= aged_win[aged_head];
          aged_win[aged_head] = evicted[7:0];
          aged_head = (aged_head + 1) % bels_pkg::WIN_DEPTH;
        end else begin
          aged_win[(aged_head + aged_cnt) % bels_pkg::WIN_DEPTH] = evicted[7:0];
          aged_cnt++;
        end
        aged_sum += evicted;
      end else begin
        recent_win[(recent_head + recent_cnt) % bels_pkg::WIN_DEPTH] = v;
        recent_cnt++;
      end
      recent_sum += v;
      if (aged_cnt != 0 && aged_sum >= aged_cnt * int'(bels_pkg::EPS_UNITS)) begin
        num = longint'(recent_sum) * longint'(aged_cnt) << 16;
        den = longint'(aged_sum) * longint'(recent_cnt);
        if (den != 0) begin
          r = num / den;
          if (r > 64'hFF_FFFF) r = 64'hFF_FFFF;
          b = top_ratio;
          if (b < r) begin
            top_ratio = r[23:0];
            top_pos = scan_pos + 11'd1 - 11'(recent_cnt);
          end else if (b > 65536 && r * 10 < 720896 && (r + 256) * 10 < (b + 256) * 7) begin
            scan_halted = 1'b1;
          end
        end
      end
    end
    if (line_end) begin
      has_report = 1'b1;
      report = '{top_pos, top_ratio, scan_halted};
      scan_pos = '0;
    end else if (scan_pos < bels_pkg::POS_MAX) begin
      scan_pos++;
    end
  endfunction

  function automatic void report_fault(input string what, input edge_report_t want,
                                       input edge_report_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: offset exp %0d got %0d, strength exp %h got %h, stop exp %0b got %0b",
               $realtime, what, want.offset, got.offset, want.strength, got.strength,
               want.stopped, got.stopped);
  endfunction

  task automatic offer(input logic [7:0] value, input logic line_end, input bit typed,
                       input edge_report_t typed_report);
    bit has_report;
    edge_report_t report;
    if (lively) begin
      while ($urandom_range(99) < 13) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_intensity <= value;
    in_last_of_line <= line_end;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_edge(value, line_end, has_report, report);
    if (has_report) pending_reports.push_back(typed ? typed_report : report);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_background(input logic [7:0] level);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= level;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    bg_level = level;
  endtask

  task automatic send_line(input int len, inout int live);
    line_shape_t shape;
    int pick, dark, bright, knee, v;
    pick = $urandom_range(99);
    shape = pick < 45 ? SHAPE_STEP : pick < 70 ? SHAPE_NOISE : pick < 90 ? SHAPE_PEAK
                                                                           : SHAPE_FLAT;
    dark = $urandom_range(24);
    bright = $urandom_range(255, 30);
    knee = $urandom_range(len);
    for (int i = 0; i < len; i++) begin
      case (shape)
        SHAPE_STEP:  v = (i < knee) ? dark : bright;
        SHAPE_NOISE: v = $urandom_range(255);
        SHAPE_PEAK:  v = (i < knee) ? dark : (i < knee + 4) ? bright : bright / 3;
        default:     v = dark;
      endcase
      if (shape != SHAPE_NOISE) v = v + int'($urandom_range(4)) - 2;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      live++;
      offer(v[7:0], i == len - 1, 1'b0, NO_EDGE);
    end
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (choke_req && !choke_done) begin
        choke_done = 1'b1;
        out_stall <= 1'b1;
        repeat (CHOKE_CYCLES) @(posedge clk);
      end
      out_stall <= lively && ($urandom_range(99) < 13);
    end
  end

  always @(posedge clk) begin : result_check
    edge_report_t want, got;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_edge_offset, out_edge_strength, out_stopped_early};
      if (pending_reports.size() == 0) begin
        report_fault("unexpected result", NO_EDGE, got);
      end else begin
        want = pending_reports.pop_front();
        if (got.offset !== want.offset || got.strength !== want.strength ||
            got.stopped !== want.stopped)
          report_fault("result mismatch", want, got);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int sent, phase, phase_end, len, pick;
    logic [7:0] levels [5];
    levels = '{8'd16, 8'd1, 8'd0, 8'd255, 8'd128};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[k]) begin
      if (directed_rows[k].kind == ROW_BACKGROUND) begin
        set_background(directed_rows[k].value);
      end else begin
        for (int i = 0; i < directed_rows[k].count; i++)
          offer(directed_rows[k].value, i == directed_rows[k].count - 1,
                directed_rows[k].typed, directed_rows[k].want);
      end
    end

    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      set_background(phase < 5 ? levels[phase] : 8'($urandom_range(255)));
      lively = (phase != 2);
      if (phase == 4) choke_req = 1'b1;
      phase_end = sent + PHASE_ITEMS;
      while (sent < phase_end && sent < RANDOM_ITEMS) begin
        pick = $urandom_range(99);
        len = pick < 30 ? $urandom_range(12, 1) : pick < 90 ? $urandom_range(40, 5)
                                                           : $urandom_range(150, 40);
        send_line(len, sent);
      end
      phase++;
    end

    drain();
    if (mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
